@@ rtl/core/sbr_pkg.sv @@
`timescale 1ns / 1ps
package sbr_pkg;

    // input transaction modes
    localparam logic [1:0] MODE_DATA = 2'd0;
    localparam logic [1:0] MODE_END  = 2'd1;
    localparam logic [1:0] MODE_POP  = 2'd2;

    localparam int unsigned IDX_W   = 64;
    localparam int unsigned CFG_W   = 9;
    localparam int unsigned POP_W   = 9;
    localparam int unsigned CNT_OUT = 4;
    localparam int unsigned PEND_O  = 9;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DRAIN_CHK,
        S_DRAIN_RD,
        S_FLUSH,
        S_EMIT_RD,
        S_EMIT_OUT
    } t_state;

endpackage

@@ rtl/core/sbr_if.sv @@
`timescale 1ns / 1ps
// input channel: one stream transaction
interface sbr_in_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    mode;
    logic [sbr_pkg::IDX_W-1:0]     stream_index;
    logic [7:0]                    data_byte;
    logic                          ends_stream;
    logic [sbr_pkg::POP_W-1:0]     pop_count;

    modport source (output valid, mode, stream_index, data_byte, ends_stream, pop_count,
                    input ready);
    modport sink   (input valid, mode, stream_index, data_byte, ends_stream, pop_count,
                    output ready);
endinterface

// output channel: one released chunk
interface sbr_out_if;
    logic                          valid;
    logic                          ready;
    logic [63:0]                   out_data;
    logic [sbr_pkg::CNT_OUT-1:0]   out_count;
    logic                          run_last;
    logic                          stream_closed;
    logic [sbr_pkg::PEND_O-1:0]    pending_bytes;

    modport source (output valid, out_data, out_count, run_last, stream_closed,
                    pending_bytes, input ready);
    modport sink   (input valid, out_data, out_count, run_last, stream_closed,
                    pending_bytes, output ready);
endinterface

@@ rtl/core/stream_byte_reassembler_core.sv @@
`timescale 1ns / 1ps
// Stream byte reassembler. Takes data bytes, end marks and pop counts on the input
// channel and returns, per input transaction, one or more chunks of up to CHUNK_BYTES
// in-order bytes; the last chunk carries run_last, and every chunk carries the stream
// status after the whole transaction. One input transaction at a time is in flight:
// it is stored, then each released byte passes a slot check and a window memory read,
// the run closes with the final slot check and the flush, then each result chunk is
// read from the chunk buffer and offered on the output, where it may stall.
// No clearing pass after reset.
module stream_byte_reassembler_core #(
    parameter int unsigned WINDOW_BYTES = 256,
    parameter int unsigned CHUNK_BYTES  = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [sbr_pkg::CFG_W-1:0]  i_cfg_wr_data,
    sbr_in_if.sink                     i_in,
    sbr_out_if.source                  o_out
);

    localparam int unsigned SLOT_W    = $clog2(WINDOW_BYTES);
    localparam int unsigned PEND_W    = $clog2(WINDOW_BYTES + 1);
    localparam int unsigned FILL_W    = $clog2(CHUNK_BYTES + 1);
    localparam int unsigned RES_DEPTH = (WINDOW_BYTES + CHUNK_BYTES - 1) / CHUNK_BYTES;
    localparam int unsigned RES_AW    = (RES_DEPTH > 1) ? $clog2(RES_DEPTH) : 1;
    localparam int unsigned RCNT_W    = $clog2(RES_DEPTH + 1);
    localparam logic [63:0]       WIN64    = 64'(WINDOW_BYTES);
    localparam logic [SLOT_W:0]   WIN_S    = (SLOT_W + 1)'(WINDOW_BYTES);
    localparam logic [SLOT_W-1:0] SLOT_MAX = SLOT_W'(WINDOW_BYTES - 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(CHUNK_BYTES - 1);

    sbr_pkg::t_state r_state, n_state;

    logic [sbr_pkg::CFG_W-1:0] r_cfg;
    logic [WINDOW_BYTES-1:0]   r_valid;
    logic [7:0]                r_win [WINDOW_BYTES];
    logic [7:0]                r_win_rd;
    logic [63:0]               r_ne;
    logic [SLOT_W-1:0]         r_ne_slot;
    logic [63:0]               r_popped;
    logic [PEND_W-1:0]         r_pending;
    logic                      r_end_known;
    logic [63:0]               r_end_pos;
    logic                      r_closed;
    logic [63:0]               r_chunk;
    logic [FILL_W-1:0]         r_fill;
    logic [RCNT_W-1:0]         r_nres;
    logic [RCNT_W-1:0]         r_ptr;

    // store-cycle decode
    logic              in_acc;
    logic [63:0]       cap;
    logic [63:0]       off_ne;
    logic [63:0]       off_pop;
    logic [63:0]       room;
    logic              in_win;
    logic              is_byte;
    logic              do_store;
    logic              do_end;
    logic              close_now;
    logic [SLOT_W:0]   slot_sum;
    logic [SLOT_W-1:0] slot;
    // drain decode
    logic              take;
    logic [63:0]       ne_inc;
    logic              hit_end;
    logic [63:0]       chunk_n;
    logic              fill_last;
    logic              flush_wr;
    logic              emit_last;
    // result buffer
    logic                          res_wr_en;
    logic [sbr_pkg::CNT_OUT+63:0]  res_wr_data;
    logic [sbr_pkg::CNT_OUT+63:0]  res_rd_data;

    assign in_acc = i_in.valid && i_in.ready;

    // acceptance window and slot of the incoming index
    always_comb begin
        cap      = (64'(r_cfg) > WIN64) ? WIN64 : 64'(r_cfg);
        off_ne   = i_in.stream_index - r_ne;
        off_pop  = i_in.stream_index - r_popped;
        room     = r_ne - r_popped;
        in_win   = (i_in.stream_index >= r_popped) && (off_pop < cap);
        is_byte  = (i_in.mode == sbr_pkg::MODE_DATA);
        slot_sum = {1'b0, r_ne_slot} + off_ne[SLOT_W:0];
        slot     = (slot_sum >= WIN_S) ? SLOT_W'(slot_sum - WIN_S) : slot_sum[SLOT_W-1:0];
        do_store = is_byte && !r_closed && (i_in.stream_index >= r_ne) && in_win
                   && !(r_end_known && (off_ne >= (r_end_pos - r_ne)))
                   && !r_valid[slot];
        do_end   = (is_byte || (i_in.mode == sbr_pkg::MODE_END)) && i_in.ends_stream
                   && !r_end_known && !r_closed && in_win;
        close_now = do_end && (is_byte ? (i_in.stream_index < r_ne)
                                       : (i_in.stream_index <= r_ne));
    end

    // drain loop decode
    always_comb begin
        take      = !r_closed && r_valid[r_ne_slot];
        ne_inc    = r_ne + 64'd1;
        hit_end   = r_end_known && (ne_inc == r_end_pos);
        fill_last = (r_fill == FILL_MAX);
        chunk_n   = r_chunk;
        chunk_n[8*r_fill +: 8] = r_win_rd;
        flush_wr  = (r_fill != '0) || (r_nres == '0);
        emit_last = (RCNT_W'(r_ptr + 1'b1) == r_nres);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sbr_pkg::S_IDLE:      if (in_acc) n_state = sbr_pkg::S_DRAIN_CHK;
            sbr_pkg::S_DRAIN_CHK: n_state = take ? sbr_pkg::S_DRAIN_RD : sbr_pkg::S_FLUSH;
            sbr_pkg::S_DRAIN_RD:  n_state = sbr_pkg::S_DRAIN_CHK;
            sbr_pkg::S_FLUSH:     n_state = sbr_pkg::S_EMIT_RD;
            sbr_pkg::S_EMIT_RD:   n_state = sbr_pkg::S_EMIT_OUT;
            sbr_pkg::S_EMIT_OUT: begin
                if (o_out.ready) begin
                    n_state = emit_last ? sbr_pkg::S_IDLE : sbr_pkg::S_EMIT_RD;
                end
            end
            default:              n_state = sbr_pkg::S_IDLE;
        endcase
    end

    // outputs and result buffer writes
    always_comb begin
        i_in.ready  = (r_state == sbr_pkg::S_IDLE);
        o_out.valid = (r_state == sbr_pkg::S_EMIT_OUT);
        res_wr_en   = 1'b0;
        res_wr_data = {sbr_pkg::CNT_OUT'(r_fill), r_chunk};
        case (r_state)
            sbr_pkg::S_DRAIN_RD: begin
                res_wr_en   = fill_last;
                res_wr_data = {sbr_pkg::CNT_OUT'(CHUNK_BYTES), chunk_n};
            end
            sbr_pkg::S_FLUSH: begin
                res_wr_en = flush_wr;
            end
            default: ;
        endcase
    end

    assign o_out.out_data      = res_rd_data[63:0];
    assign o_out.out_count     = res_rd_data[sbr_pkg::CNT_OUT+63:64];
    assign o_out.run_last      = emit_last;
    assign o_out.stream_closed = r_closed;
    assign o_out.pending_bytes = sbr_pkg::PEND_O'(r_pending);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sbr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // stream state and run sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= sbr_pkg::CFG_W'(256);
            r_valid     <= '0;
            r_ne        <= '0;
            r_ne_slot   <= '0;
            r_popped    <= '0;
            r_pending   <= '0;
            r_end_known <= 1'b0;
            r_end_pos   <= '0;
            r_closed    <= 1'b0;
            r_fill      <= '0;
            r_nres      <= '0;
            r_ptr       <= '0;
            r_chunk     <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cfg <= i_cfg_wr_data;
            end
            case (r_state)
                sbr_pkg::S_IDLE: begin
                    if (in_acc) begin
                        r_fill  <= '0;
                        r_nres  <= '0;
                        r_chunk <= '0;
                        if (do_end) begin
                            r_end_known <= 1'b1;
                            r_end_pos   <= i_in.stream_index + {63'd0, is_byte};
                        end
                        if (close_now) begin
                            r_closed  <= 1'b1;
                            r_valid   <= '0;
                            r_pending <= '0;
                        end else if (do_store) begin
                            r_valid[slot] <= 1'b1;
                            r_pending     <= r_pending + 1'b1;
                        end
                        if (i_in.mode == sbr_pkg::MODE_POP) begin
                            r_popped <= r_popped + ((64'(i_in.pop_count) < room)
                                                    ? 64'(i_in.pop_count) : room);
                        end
                    end
                end
                sbr_pkg::S_DRAIN_CHK: begin
                    if (take) begin
                        r_ne      <= ne_inc;
                        r_ne_slot <= (r_ne_slot == SLOT_MAX) ? '0 : r_ne_slot + 1'b1;
                        if (hit_end) begin
                            r_closed  <= 1'b1;
                            r_valid   <= '0;
                            r_pending <= '0;
                        end else begin
                            r_valid[r_ne_slot] <= 1'b0;
                            r_pending          <= r_pending - 1'b1;
                        end
                    end
                end
                sbr_pkg::S_DRAIN_RD: begin
                    if (fill_last) begin
                        r_fill  <= '0;
                        r_chunk <= '0;
                        r_nres  <= r_nres + 1'b1;
                    end else begin
                        r_fill  <= r_fill + 1'b1;
                        r_chunk <= chunk_n;
                    end
                end
                sbr_pkg::S_FLUSH: begin
                    r_ptr <= '0;
                    if (flush_wr) begin
                        r_nres <= r_nres + 1'b1;
                    end
                end
                sbr_pkg::S_EMIT_OUT: begin
                    if (o_out.ready) begin
                        r_ptr <= r_ptr + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // window store: write on store, read at the next expected slot
    always_ff @(posedge i_clk) begin
        if (in_acc && do_store) begin
            r_win[slot] <= i_in.data_byte;
        end
        r_win_rd <= r_win[r_ne_slot];
    end

    sbr_result_buf #(
        .DEPTH  (RES_DEPTH),
        .ADDR_W (RES_AW)
    ) u_res (
        .i_clk     (i_clk),
        .i_wr_en   (res_wr_en),
        .i_wr_addr (r_nres[RES_AW-1:0]),
        .i_wr_data (res_wr_data),
        .i_rd_addr (r_ptr[RES_AW-1:0]),
        .o_rd_data (res_rd_data)
    );

endmodule

@@ rtl/core/sbr_result_buf.sv @@
`timescale 1ns / 1ps
// chunk buffer: collects the chunks of one run until its status is final
module sbr_result_buf #(
    parameter int unsigned DEPTH  = 32,
    parameter int unsigned ADDR_W = 5
) (
    input  logic                            i_clk,
    input  logic                            i_wr_en,
    input  logic [ADDR_W-1:0]               i_wr_addr,
    input  logic [sbr_pkg::CNT_OUT+63:0]    i_wr_data,
    input  logic [ADDR_W-1:0]               i_rd_addr,
    output logic [sbr_pkg::CNT_OUT+63:0]    o_rd_data
);

    logic [sbr_pkg::CNT_OUT+63:0] r_mem [DEPTH];
    logic [sbr_pkg::CNT_OUT+63:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd;

endmodule
